[src/lkv_pkg.sv]
package lkv_pkg;

    // request opcodes
    typedef enum logic [1:0] {
        OP_CONTAINS = 2'd0,
        OP_GET      = 2'd1,
        OP_INSERT   = 2'd2,
        OP_CLEAR    = 2'd3
    } t_opcode;

    // widths of the fixed fields
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CAP_W   = 4;
    localparam int unsigned OCC_W   = 4;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

[src/lkv_ctrl.sv]
module lkv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_done,
    output lkv_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and result strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_EXEC);
        end
    end

    // commands to the datapath
    assign o_cmd.capture = (r_state == ST_IDLE) && start;
    assign o_cmd.execute = (r_state == ST_EXEC);
    assign busy          = (r_state == ST_EXEC);
    assign o_done        = r_done;

endmodule

[src/lkv_dpath.sv]
module lkv_dpath #(
    parameter int unsigned ENTRIES    = 8,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lkv_pkg::t_dp_cmd              i_cmd,
    input  logic                          i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  logic [1:0]                    i_opcode,
    input  logic [lkv_pkg::KEY_W-1:0]     i_key,
    input  logic [lkv_pkg::VALUE_W-1:0]   i_value_in,
    output logic                          o_status,
    output logic                          o_found,
    output logic [lkv_pkg::VALUE_W-1:0]   o_value_out,
    output logic                          o_evicted,
    output logic [lkv_pkg::OCC_W-1:0]     o_occupancy
);

    localparam int unsigned RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW   = $clog2(ENTRIES + 1);
    localparam int unsigned CMPW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;
    localparam int unsigned VW   = (VALUE_BITS > lkv_pkg::VALUE_W) ? VALUE_BITS
                                                                     : lkv_pkg::VALUE_W;

    // request registers
    lkv_pkg::t_opcode               r_op;
    logic [lkv_pkg::KEY_W-1:0]      r_key;
    logic [VALUE_BITS-1:0]          r_val;
    logic [VW-1:0]                  vin_ext;

    // table storage
    logic [lkv_pkg::KEY_W-1:0]      r_keys [ENTRIES];
    logic [VALUE_BITS-1:0]          r_vals [ENTRIES];
    logic [ENTRIES-1:0]             r_valid;
    logic [RW-1:0]                  r_rank [ENTRIES];
    logic [CW-1:0]                  r_count;
    logic [lkv_pkg::CAP_W-1:0]      r_capacity;

    // next values
    logic [ENTRIES-1:0]             n_valid;
    logic [RW-1:0]                  n_rank [ENTRIES];
    logic [CW-1:0]                  n_count;

    // lookup and replacement
    logic [ENTRIES-1:0]             hit_vec;
    logic                           hit_any;
    logic [VALUE_BITS-1:0]          hit_val;
    logic [RW-1:0]                  hit_rank;
    logic [ENTRIES-1:0]             victim_vec;
    logic [ENTRIES-1:0]             free_vec;
    logic [ENTRIES-1:0]             slot_vec;
    logic                           slot_taken;
    logic                           slot_ok;
    logic                           do_evict;
    logic [CMPW-1:0]                cap_ext;
    logic [CMPW-1:0]                eff_cap;
    logic [CMPW-1:0]                cnt_ext;
    logic [ENTRIES-1:0]             key_we;
    logic [ENTRIES-1:0]             val_we;

    // result values
    logic                           res_status;
    logic                           res_found;
    logic [VW-1:0]                  vout_ext;
    logic                           res_get_hit;
    logic [CMPW-1:0]                occ_ext;

    assign vin_ext = VW'(i_value_in);

    // capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= lkv_pkg::t_opcode'(i_opcode);
            r_key <= i_key;
            r_val <= vin_ext[VALUE_BITS-1:0];
        end
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkv_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // parallel key compare
    always_comb begin
        hit_val  = '0;
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_keys[i] == r_key);
            if (hit_vec[i]) begin
                hit_val  = r_vals[i];
                hit_rank = r_rank[i];
            end
        end
        hit_any = |hit_vec;
    end

    // effective capacity and full check
    assign cap_ext = CMPW'(r_capacity);
    assign eff_cap = ((r_capacity == '0) || (cap_ext > CMPW'(ENTRIES))) ? CMPW'(ENTRIES)
                                                                        : cap_ext;
    assign cnt_ext = CMPW'(r_count);
    assign do_evict = (r_op == lkv_pkg::OP_INSERT) && !hit_any && (cnt_ext >= eff_cap);

    // victim is the valid entry holding the oldest rank
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            victim_vec[i] = r_valid[i] && (CW'(r_rank[i]) == (r_count - CW'(1)));
        end
    end

    // first free slot once the victim is gone
    always_comb begin
        free_vec   = r_valid & ~(do_evict ? victim_vec : '0);
        slot_vec   = '0;
        slot_taken = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!free_vec[i] && !slot_taken) begin
                slot_vec[i] = 1'b1;
                slot_taken  = 1'b1;
            end
        end
        slot_ok = slot_taken;
    end

    // next valid bits, ranks and count
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        key_we  = '0;
        val_we  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end
        case (r_op)
            lkv_pkg::OP_GET, lkv_pkg::OP_INSERT: begin
                if (hit_any) begin
                    // promote the hit entry, younger entries age by one
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (hit_vec[i]) begin
                            n_rank[i] = '0;
                        end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                            n_rank[i] = r_rank[i] + RW'(1);
                        end
                    end
                    if (r_op == lkv_pkg::OP_INSERT) begin
                        val_we = hit_vec;
                    end
                end else if (r_op == lkv_pkg::OP_INSERT) begin
                    // evict if full, then add as most recent
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (do_evict && victim_vec[i]) begin
                            n_valid[i] = 1'b0;
                            n_rank[i]  = '0;
                        end
                        if (free_vec[i]) begin
                            n_rank[i] = r_rank[i] + RW'(1);
                        end
                        if (slot_ok && slot_vec[i]) begin
                            n_valid[i] = 1'b1;
                            n_rank[i]  = '0;
                        end
                    end
                    key_we = slot_ok ? slot_vec : '0;
                    val_we = slot_ok ? slot_vec : '0;
                    if (slot_ok && !do_evict) begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            lkv_pkg::OP_CLEAR: begin
                n_valid = '0;
                n_count = '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    n_rank[i] = '0;
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    // table control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.execute) begin
            r_valid <= n_valid;
            r_count <= n_count;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // key and value storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (key_we[i]) begin
                    r_keys[i] <= r_key;
                end
                if (val_we[i]) begin
                    r_vals[i] <= r_val;
                end
            end
        end
    end

    // result fields
    assign res_get_hit = (r_op == lkv_pkg::OP_GET) && hit_any;
    assign res_status  = (r_op == lkv_pkg::OP_GET) && !hit_any;
    assign res_found   = hit_any && (r_op != lkv_pkg::OP_CLEAR);
    assign vout_ext    = res_get_hit ? VW'(hit_val) : '0;
    assign occ_ext     = CMPW'(n_count);

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            o_status    <= res_status;
            o_found     <= res_found;
            o_value_out <= vout_ext[lkv_pkg::VALUE_W-1:0];
            o_evicted   <= do_evict;
            o_occupancy <= occ_ext[lkv_pkg::OCC_W-1:0];
        end
    end

endmodule

[src/lru_key_value_cache_top.sv]
// LRU key/value cache: a small fully associative table with least-recently-used
// replacement.
//
// Request channel: drive i_opcode, i_key and i_value_in with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// Opcodes: contains, get, insert or update, clear.
// Result channel: o_done is high for exactly one cycle, together with o_status,
// o_found, o_value_out, o_evicted and o_occupancy. The receiver cannot stall;
// the result must be taken in that cycle.
// Sequencing: the accepting edge captures the request, the controller enters the
// execute state, and leaving it registers the result and raises o_done. busy is
// high for the single execute cycle, so no new request is taken while one executes.
// The execute cycle holds the parallel key compare over all entries and the
// rank update.
// Configuration: i_cfg_we with i_cfg_wdata writes the capacity register (zero
// means the full table); write it only while no request is in flight.
// Reset (i_rst_n low, synchronous): the table is empty, capacity returns to 8
// and no result is pending.
module lru_key_value_cache_top #(
    parameter int unsigned ENTRIES    = 8,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [lkv_pkg::KEY_W-1:0]     i_key,
    input  logic [lkv_pkg::VALUE_W-1:0]   i_value_in,
    input  logic                          i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]     i_cfg_wdata,
    output logic                          o_done,
    output logic                          o_status,
    output logic                          o_found,
    output logic [lkv_pkg::VALUE_W-1:0]   o_value_out,
    output logic                          o_evicted,
    output logic [lkv_pkg::OCC_W-1:0]     o_occupancy
);

    lkv_pkg::t_dp_cmd dp_cmd;

    // sequencing
    lkv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd)
    );

    // table and result datapath
    lkv_dpath #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_opcode    (i_opcode),
        .i_key       (i_key),
        .i_value_in  (i_value_in),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_value_out (o_value_out),
        .o_evicted   (o_evicted),
        .o_occupancy (o_occupancy)
    );

`ifndef SYNTHESIS
    // every accepted transaction gives its result once the execute state is over
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("accepted transaction produced no result");

    // a result only follows an execute cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without execute cycle");

    // eviction only happens for a new key
    a_evict_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_evicted) |-> (!o_found && !o_status))
        else $error("eviction reported on a hit");

    // the execute state never follows itself: busy is not high in back-to-back cycles
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("execute lasted more than one cycle");
`endif

endmodule

[bench/lru_key_value_cache_top_tb.sv]
`timescale 1ns / 1ps

module lru_key_value_cache_top_tb;

    localparam int SLOTS          = 8;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 4;
    localparam int STALL_LIMIT    = 1000;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_ITEMS    = 140;
    localparam logic [lkv_pkg::CAP_W-1:0] PHASE_CAPS [PHASE_COUNT] =
        '{4'd15, 4'd1, 4'd0, 4'd5, 4'd2, 4'd8, 4'd9, 4'd3, 4'd6, 4'd4};

    // one result transaction
    typedef struct packed {
        logic                        status;
        logic                        found;
        logic [lkv_pkg::VALUE_W-1:0] value_out;
        logic                        evicted;
        logic [lkv_pkg::OCC_W-1:0]   occupancy;
    } t_cache_result;

    // shadow lru table plus the queue of results it predicts
    class lru_cache_scoreboard;
        logic [lkv_pkg::KEY_W-1:0]   key_store   [SLOTS];
        logic [lkv_pkg::VALUE_W-1:0] value_store [SLOTS];
        bit                          slot_valid  [SLOTS];
        int unsigned                 slot_rank   [SLOTS];
        logic [lkv_pkg::CAP_W-1:0]   capacity;
        t_cache_result               expected_results [$];
        int unsigned                 mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                key_store[i]   = '0;
                value_store[i] = '0;
                slot_valid[i]  = 1'b0;
                slot_rank[i]   = 0;
            end
            capacity   = lkv_pkg::CAP_RESET;
            mismatches = 0;
        endfunction

        function int unsigned occupied();
            int unsigned n;
            n = 0;
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i]) n++;
            return n;
        endfunction

        // move a slot to most recent, the more recent ones age by one
        function void promote(int s);
            int unsigned r;
            r = slot_rank[s];
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
            slot_rank[s] = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // predict the result of an accepted request transaction
        function void note_request(lkv_pkg::t_opcode op, logic [lkv_pkg::KEY_W-1:0] key,
                                   logic [lkv_pkg::VALUE_W-1:0] val);
            t_cache_result r;
            int            hit;
            int            victim;
            int            slot;
            int unsigned   cap_eff;
            r   = '0;
            hit = -1;
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && slot_valid[i] && key_store[i] == key) hit = i;
            case (op)
                lkv_pkg::OP_CONTAINS: begin
                    r.found = (hit >= 0);
                end
                lkv_pkg::OP_GET: begin
                    if (hit >= 0) begin
                        r.found     = 1'b1;
                        r.value_out = value_store[hit];
                        promote(hit);
                    end else begin
                        r.status = 1'b1;
                    end
                end
                lkv_pkg::OP_INSERT: begin
                    if (hit >= 0) begin
                        r.found          = 1'b1;
                        value_store[hit] = val;
                        promote(hit);
                    end else begin
                        cap_eff = (capacity == 0 || capacity > SLOTS) ? SLOTS : capacity;
                        // full at the effective capacity: drop the least recent
                        if (occupied() >= cap_eff) begin
                            victim = -1;
                            for (int i = 0; i < SLOTS; i++)
                                if (slot_valid[i] &&
                                    (victim < 0 || slot_rank[i] > slot_rank[victim]))
                                    victim = i;
                            if (victim >= 0) begin
                                slot_valid[victim] = 1'b0;
                                slot_rank[victim]  = 0;
                            end
                            r.evicted = 1'b1;
                        end
                        // new key goes into the first free slot as most recent
                        slot = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (slot < 0 && !slot_valid[i]) slot = i;
                        if (slot >= 0) begin
                            for (int i = 0; i < SLOTS; i++)
                                if (slot_valid[i]) slot_rank[i]++;
                            key_store[slot]   = key;
                            value_store[slot] = val;
                            slot_valid[slot]  = 1'b1;
                            slot_rank[slot]   = 0;
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        slot_valid[i] = 1'b0;
                        slot_rank[i]  = 0;
                    end
                end
            endcase
            r.occupancy = lkv_pkg::OCC_W'(occupied());
            expected_results.push_back(r);
        endfunction

        // compare a result transaction with the oldest prediction
        function void check_result(t_cache_result got);
            t_cache_result exp_r;
            bit            bad;
            if (expected_results.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("%0t: result with no request outstanding: status=%0b found=%0b value=%h evicted=%0b occ=%0d",
                             $realtime, got.status, got.found, got.value_out,
                             got.evicted, got.occupancy);
                mismatches++;
                return;
            end
            exp_r = expected_results.pop_front();
            bad = (got.status    !== exp_r.status)    ||
                  (got.found     !== exp_r.found)     ||
                  (got.value_out !== exp_r.value_out) ||
                  (got.evicted   !== exp_r.evicted)   ||
                  (got.occupancy !== exp_r.occupancy);
            if (bad) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected status=%0b found=%0b value=%h evicted=%0b occ=%0d",
                             exp_r.status, exp_r.found, exp_r.value_out,
                             exp_r.evicted, exp_r.occupancy);
                    $display("  actual   status=%0b found=%0b value=%h evicted=%0b occ=%0d",
                             got.status, got.found, got.value_out,
                             got.evicted, got.occupancy);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n     = 1'b0;
    logic                        start       = 1'b0;
    logic                        busy;
    lkv_pkg::t_opcode            req_op      = lkv_pkg::OP_CONTAINS;
    logic [lkv_pkg::KEY_W-1:0]   i_key       = '0;
    logic [lkv_pkg::VALUE_W-1:0] i_value_in  = '0;
    logic                        i_cfg_we    = 1'b0;
    logic [lkv_pkg::CAP_W-1:0]   i_cfg_wdata = '0;
    logic                        o_done;
    logic                        o_status;
    logic                        o_found;
    logic [lkv_pkg::VALUE_W-1:0] o_value_out;
    logic                        o_evicted;
    logic [lkv_pkg::OCC_W-1:0]   o_occupancy;

    lru_cache_scoreboard sb;
    int                  idle_pct;
    int                  stall_count = 0;

    lru_key_value_cache_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (req_op),
        .i_key       (i_key),
        .i_value_in  (i_value_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_value_out (o_value_out),
        .o_evicted   (o_evicted),
        .o_occupancy (o_occupancy)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // result monitor, every strobe is taken
    always @(posedge i_clk) begin
        t_cache_result seen;
        if (i_rst_n && o_done === 1'b1) begin
            seen.status    = o_status;
            seen.found     = o_found;
            seen.value_out = o_value_out;
            seen.evicted   = o_evicted;
            seen.occupancy = o_occupancy;
            sb.check_result(seen);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // present a request and hold it until the block takes it
    task automatic send(input lkv_pkg::t_opcode op, input logic [lkv_pkg::KEY_W-1:0] key,
                        input logic [lkv_pkg::VALUE_W-1:0] val);
        req_op     <= op;
        i_key      <= key;
        i_value_in <= val;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(op, key, val);
    endtask

    // random gap between requests
    task automatic maybe_idle();
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // hold off until every predicted result has come back
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // capacity write with the block idle
    task automatic set_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.capacity = cap;
    endtask

    // random traffic over a small key pool so hits and evictions are common
    task automatic run_phase(input logic [lkv_pkg::CAP_W-1:0] cap, input int n_items);
        logic [lkv_pkg::KEY_W-1:0] pool [16];
        int                        pool_n;
        int                        pick;
        int                        drain_at;
        int                        n;
        lkv_pkg::t_opcode          op;
        logic [lkv_pkg::KEY_W-1:0] key;
        set_capacity(cap);
        pool_n = $urandom_range(2, 14);
        for (int i = 0; i < pool_n; i++) pool[i] = $urandom();
        drain_at = $urandom_range(0, n_items - 1);
        for (n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)       op = lkv_pkg::OP_CLEAR;
            else if (pick < 42) op = lkv_pkg::OP_INSERT;
            else if (pick < 72) op = lkv_pkg::OP_GET;
            else                op = lkv_pkg::OP_CONTAINS;
            if ($urandom_range(0, 9) == 0) key = $urandom();
            else                           key = pool[$urandom_range(0, pool_n - 1)];
            send(op, key, $urandom());
            if (n == drain_at) drain();
            else maybe_idle();
        end
    endtask

    // stimulus
    initial begin
        sb       = new();
        idle_pct = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lookups on an empty table, then the key and value extremes
        send(lkv_pkg::OP_CONTAINS, 32'h0000_0000, 32'h0);
        send(lkv_pkg::OP_GET,      32'h0000_0000, 32'hFFFF_FFFF);
        send(lkv_pkg::OP_INSERT,   32'h0000_0000, 32'hFFFF_FFFF);
        send(lkv_pkg::OP_INSERT,   32'hFFFF_FFFF, 32'h0000_0000);
        send(lkv_pkg::OP_GET,      32'h0000_0000, 32'h0);
        send(lkv_pkg::OP_CONTAINS, 32'hFFFF_FFFF, 32'h0);
        // update of a present key promotes it and evicts nothing
        send(lkv_pkg::OP_INSERT,   32'h0000_0000, 32'h1234_5678);
        send(lkv_pkg::OP_GET,      32'h0000_0000, 32'h0);
        // fill the table, then one more new key evicts the least recent
        for (int k = 1; k <= 6; k++) send(lkv_pkg::OP_INSERT, k, $urandom());
        send(lkv_pkg::OP_INSERT,   32'h0000_0007, 32'hA5A5_5A5A);
        send(lkv_pkg::OP_GET,      32'hFFFF_FFFF, 32'h0);
        send(lkv_pkg::OP_CONTAINS, 32'h0000_0003, 32'h0);

        // capacity lowered below occupancy: one eviction per new key
        set_capacity(4'd3);
        send(lkv_pkg::OP_INSERT,   32'h0000_0100, 32'h0BAD_F00D);
        send(lkv_pkg::OP_INSERT,   32'h0000_0101, 32'hDEAD_BEEF);
        send(lkv_pkg::OP_INSERT,   32'h0000_0001, 32'h5555_AAAA);
        // clear empties the table
        send(lkv_pkg::OP_CLEAR,    32'h0000_0001, 32'hFFFF_FFFF);
        send(lkv_pkg::OP_GET,      32'h0000_0001, 32'h0);
        send(lkv_pkg::OP_CLEAR,    32'h0000_0000, 32'h0);

        // random phases over a spread of capacities, the first without gaps
        for (int p = 0; p < PHASE_COUNT; p++) begin
            idle_pct = (p == 0) ? 0 : 7;
            run_phase(PHASE_CAPS[p], PHASE_ITEMS);
        end

        // wind down
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
src/lkv_pkg.sv
src/lkv_ctrl.sv
src/lkv_dpath.sv
src/lru_key_value_cache_top.sv
bench/lru_key_value_cache_top_tb.sv
